[rtl/core/leg_inverse_kinematics_3dof_core_macros.svh]
`ifndef LEG_INVERSE_KINEMATICS_3DOF_CORE_MACROS_SVH
`define LEG_INVERSE_KINEMATICS_3DOF_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LIK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lik assertion failed");
`define LIK_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lik assertion failed");
`else
`define LIK_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LIK_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/lik_pkg.sv]
package lik_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int TAB_LEN       = 24;
    localparam int CW            = 45;
    localparam int LAT_CORDIC    = CORDIC_STAGES + 8;

    localparam int SQ_IN_W   = 62;
    localparam int SQ_STEPS  = 31;
    localparam int SQ_REM_W  = 33;
    localparam int LAT_SQRT  = SQ_STEPS;

    localparam int DIV_W     = 41;
    localparam int DIV_STEPS = 30;
    localparam int LAT_DIV   = DIV_STEPS;

    localparam int ST_R    = 2 + LAT_SQRT;
    localparam int ST_D    = ST_R + 1;
    localparam int ST_A2   = ST_D + 2;
    localparam int ST_A    = ST_A2 + LAT_SQRT;
    localparam int ST_NUM  = ST_A + 1;
    localparam int ST_PREP = ST_NUM + 1;
    localparam int ST_Q    = ST_PREP + LAT_DIV;
    localparam int ST_C    = ST_Q + 1;
    localparam int ST_SV   = ST_C + 2;
    localparam int ST_S    = ST_SV + LAT_SQRT;
    localparam int ST_F    = ST_S + LAT_CORDIC;

    localparam int DLY_Z    = ST_R;
    localparam int DLY_A2   = ST_A - ST_A2;
    localparam int DLY_CTL  = ST_Q - ST_PREP;
    localparam int DLY_CZ   = ST_S - ST_C;
    localparam int DLY_FLAG = ST_F - ST_C;
    localparam int DLY_YAW  = ST_F - LAT_CORDIC;
    localparam int DLY_BETA = ST_F - (ST_D + LAT_CORDIC);

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_LINK1 = 2'd0;
    localparam t_reg_idx REG_LINK2 = 2'd1;
    localparam t_reg_idx REG_LINK3 = 2'd2;

    typedef struct packed {
        logic signed [19:0] target_x;
        logic signed [19:0] target_y;
        logic signed [19:0] target_z;
    } t_in;

    typedef struct packed {
        logic signed [15:0] yaw_angle;
        logic signed [15:0] hip_angle;
        logic signed [15:0] knee_angle;
        logic               out_of_reach;
    } t_out;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [31:0]          ang;
        logic                 zero;
    } t_cord;

    typedef struct packed {
        logic neg;
        logic sat;
        logic flag;
        logic zero;
    } t_acos_ctl;

    function automatic logic [31:0] f_atan(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/lik_cordic_cell.sv]
module lik_cordic_cell (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [4:0]     i_stage,
    input  lik_pkg::t_cord i_d,
    output lik_pkg::t_cord o_d
);

    lik_pkg::t_cord              r_d;
    lik_pkg::t_cord              n_d;
    logic signed [lik_pkg::CW-1:0] w_dx;
    logic signed [lik_pkg::CW-1:0] w_dy;

    always_comb begin
        w_dx = i_d.y >>> i_stage;
        w_dy = i_d.x >>> i_stage;
        n_d  = i_d;
        if (i_d.y > 0) begin
            n_d.x   = i_d.x + w_dx;
            n_d.y   = i_d.y - w_dy;
            n_d.ang = i_d.ang + lik_pkg::f_atan(i_stage);
        end else begin
            n_d.x   = i_d.x - w_dx;
            n_d.y   = i_d.y + w_dy;
            n_d.ang = i_d.ang - lik_pkg::f_atan(i_stage);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

[rtl/core/lik_cordic.sv]
module lik_cordic (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_y,
    input  logic signed [31:0] i_x,
    input  logic               i_force_zero,
    output logic [31:0]        o_ang
);

    localparam int CW = lik_pkg::CW;

    function automatic logic [CW-1:0] f_mag(input logic signed [CW-1:0] v);
        logic [CW-1:0] m;
        m = v[CW-1] ? CW'(-v) : CW'(v);
        return m;
    endfunction

    lik_pkg::t_cord r_nm [7];
    lik_pkg::t_cord r_q;
    lik_pkg::t_cord n_q;
    lik_pkg::t_cord w_c [lik_pkg::CORDIC_STAGES+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nm[0].x    <= {{(CW-32){i_x[31]}}, i_x};
            r_nm[0].y    <= {{(CW-32){i_y[31]}}, i_y};
            r_nm[0].ang  <= '0;
            r_nm[0].zero <= (i_x == 32'sd0 && i_y == 32'sd0) || i_force_zero;
        end
    end

    for (genvar k = 0; k < 6; k++) begin : g_norm
        localparam int Sh  = 32 >> k;
        localparam int Lim = 41 - Sh;
        logic [CW-1:0]  w_or;
        lik_pkg::t_cord n_d;
        always_comb begin
            w_or = f_mag(r_nm[k].x) | f_mag(r_nm[k].y);
            n_d  = r_nm[k];
            if (w_or[CW-1:Lim] == '0) begin
                n_d.x = r_nm[k].x <<< Sh;
                n_d.y = r_nm[k].y <<< Sh;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nm[k+1] <= n_d;
            end
        end
    end

    always_comb begin
        n_q = r_nm[6];
        if (r_nm[6].x < 0) begin
            if (r_nm[6].y >= 0) begin
                n_q.x   = r_nm[6].y;
                n_q.y   = -r_nm[6].x;
                n_q.ang = 32'h4000_0000;
            end else begin
                n_q.x   = -r_nm[6].y;
                n_q.y   = r_nm[6].x;
                n_q.ang = 32'hC000_0000;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign w_c[0] = r_q;

    for (genvar k = 0; k < lik_pkg::CORDIC_STAGES; k++) begin : g_cell
        lik_cordic_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_stage(5'(k)),
            .i_d    (w_c[k]),
            .o_d    (w_c[k+1])
        );
    end

    assign o_ang = w_c[lik_pkg::CORDIC_STAGES].zero ? '0 : w_c[lik_pkg::CORDIC_STAGES].ang;

endmodule

[rtl/core/lik_sqrt.sv]
module lik_sqrt (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [lik_pkg::SQ_IN_W-1:0] i_v,
    output logic [lik_pkg::SQ_STEPS-1:0] o_root
);

    localparam int VW = lik_pkg::SQ_IN_W;
    localparam int RW = lik_pkg::SQ_STEPS;
    localparam int EW = lik_pkg::SQ_REM_W;
    localparam int N  = lik_pkg::SQ_STEPS;

    logic [VW-1:0] r_v    [N];
    logic [EW-1:0] r_rem  [N];
    logic [RW-1:0] r_root [N];

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [VW-1:0] w_vi;
        logic [EW-1:0] w_ri;
        logic [RW-1:0] w_qi;
        logic [EW+1:0] w_rem4;
        logic [EW+1:0] w_trial;
        logic          w_ge;
        if (k == 0) begin : g_first
            assign w_vi = i_v;
            assign w_ri = '0;
            assign w_qi = '0;
        end else begin : g_next
            assign w_vi = r_v[k-1];
            assign w_ri = r_rem[k-1];
            assign w_qi = r_root[k-1];
        end
        always_comb begin
            w_rem4  = {w_ri, w_vi[VW-1:VW-2]};
            w_trial = (EW+2)'({w_qi, 2'b01});
            w_ge    = w_rem4 >= w_trial;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[k]    <= {w_vi[VW-3:0], 2'b00};
                r_rem[k]  <= w_ge ? EW'(w_rem4 - w_trial) : w_rem4[EW-1:0];
                r_root[k] <= {w_qi[RW-2:0], w_ge};
            end
        end
    end

    assign o_root = r_root[N-1];

endmodule

[rtl/core/lik_div.sv]
module lik_div (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [lik_pkg::DIV_W-1:0]      i_m,
    input  logic [lik_pkg::DIV_W-1:0]      i_den,
    output logic [lik_pkg::DIV_STEPS-1:0]  o_q
);

    localparam int W = lik_pkg::DIV_W;
    localparam int N = lik_pkg::DIV_STEPS;

    logic [W-1:0] r_rem [N];
    logic [W-1:0] r_den [N];
    logic [N-1:0] r_q   [N];

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [W-1:0] w_ri;
        logic [W-1:0] w_di;
        logic [N-1:0] w_qi;
        logic [W:0]   w_rem2;
        logic         w_ge;
        if (k == 0) begin : g_first
            assign w_ri = i_m;
            assign w_di = i_den;
            assign w_qi = '0;
        end else begin : g_next
            assign w_ri = r_rem[k-1];
            assign w_di = r_den[k-1];
            assign w_qi = r_q[k-1];
        end
        always_comb begin
            w_rem2 = {w_ri, 1'b0};
            w_ge   = w_rem2 >= {1'b0, w_di};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? W'(w_rem2 - {1'b0, w_di}) : w_rem2[W-1:0];
                r_den[k] <= w_di;
                r_q[k]   <= {w_qi[N-2:0], w_ge};
            end
        end
    end

    assign o_q = r_q[N-1];

endmodule

[rtl/core/leg_inverse_kinematics_3dof_core.sv]
// Three-link leg inverse kinematics. Each item is a foot target (x, y, z) in
// 1/64 mm; the result gives hip yaw, hip pitch and knee as 16-bit binary
// angles (32768 = pi) and an out-of-reach flag. One item enters per clock
// while the output is not stalled; items pass through a chain of square-root,
// divider and CORDIC cells. A stall on the output freezes the whole chain
// and stalls the input. The user must write link lengths through the
// configuration port only while idle; the block does not enforce this.
`include "leg_inverse_kinematics_3dof_core_macros.svh"

module leg_inverse_kinematics_3dof_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  lik_pkg::t_in        i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output lik_pkg::t_out       o_out_data,
    input  logic                i_out_stall,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  lik_pkg::t_reg_idx   i_cfg_index,
    input  logic [18:0]         i_cfg_data
);

    localparam int ST_F = lik_pkg::ST_F;

    logic        w_en;
    logic [18:0] r_l1;
    logic [18:0] r_l2;
    logic [18:0] r_l3;
    logic [37:0] r_l2sq;
    logic [37:0] r_l3sq;
    logic [40:0] r_den1;
    logic [37:0] w_l23;

    logic [ST_F:0]      r_vld;
    logic               r_out_valid;
    lik_pkg::t_out      r_out;

    logic signed [19:0] r_x0;
    logic signed [19:0] r_y0;
    logic signed [19:0] r_z0;
    logic signed [39:0] w_xx;
    logic signed [39:0] w_yy;
    logic [38:0]        r_xx;
    logic [38:0]        r_yy;
    logic [39:0]        r_rsq;
    logic [30:0]        w_r;
    logic signed [19:0] r_zd [lik_pkg::DLY_Z];
    logic signed [20:0] r_d;
    logic signed [19:0] r_z34;
    logic signed [41:0] w_dd;
    logic signed [39:0] w_zz;
    logic [39:0]        r_dd;
    logic [38:0]        r_zz;
    logic [39:0]        r_a2;
    logic [39:0]        r_a2d [lik_pkg::DLY_A2];
    logic [30:0]        w_a;
    logic [38:0]        w_al2;

    logic signed [41:0] w_num [2];
    logic [40:0]        w_den [2];
    logic [31:0]        w_ang [2];
    logic               w_fl  [2];

    logic [31:0] w_yaw;
    logic [31:0] w_beta;
    logic [31:0] r_yawd  [lik_pkg::DLY_YAW];
    logic [31:0] r_betad [lik_pkg::DLY_BETA];
    logic        r_fld   [lik_pkg::DLY_FLAG];
    logic [31:0] w_hip;
    logic [31:0] w_knee;
    logic [31:0] w_yaw_r;
    logic [31:0] w_hip_r;
    logic [31:0] w_knee_r;

    assign w_en        = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !w_en;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1 <= '0;
            r_l2 <= '0;
            r_l3 <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lik_pkg::REG_LINK1: r_l1 <= i_cfg_data;
                lik_pkg::REG_LINK2: r_l2 <= i_cfg_data;
                lik_pkg::REG_LINK3: r_l3 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_l23 = r_l2 * r_l3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l2sq <= '0;
            r_l3sq <= '0;
            r_den1 <= '0;
        end else begin
            r_l2sq <= r_l2 * r_l2;
            r_l3sq <= r_l3 * r_l3;
            r_den1 <= 41'({w_l23, 1'b0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vld       <= {r_vld[ST_F-1:0], i_in_valid};
            r_out_valid <= r_vld[ST_F];
        end
    end

    assign w_xx = r_x0 * r_x0;
    assign w_yy = r_y0 * r_y0;
    assign w_dd = r_d * r_d;
    assign w_zz = r_z34 * r_z34;
    assign w_al2 = w_a[19:0] * r_l2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x0  <= i_in_data.target_x;
            r_y0  <= i_in_data.target_y;
            r_z0  <= i_in_data.target_z;
            r_xx  <= w_xx[38:0];
            r_yy  <= w_yy[38:0];
            r_rsq <= {1'b0, r_xx} + {1'b0, r_yy};
            r_zd[0] <= r_z0;
            for (int k = 1; k < lik_pkg::DLY_Z; k++) begin
                r_zd[k] <= r_zd[k-1];
            end
            r_d   <= $signed({1'b0, w_r[19:0]}) - $signed({2'b00, r_l1});
            r_z34 <= r_zd[lik_pkg::DLY_Z-1];
            r_dd  <= w_dd[39:0];
            r_zz  <= w_zz[38:0];
            r_a2  <= r_dd + {1'b0, r_zz};
            r_a2d[0] <= r_a2;
            for (int k = 1; k < lik_pkg::DLY_A2; k++) begin
                r_a2d[k] <= r_a2d[k-1];
            end
        end
    end

    lik_cordic u_yaw (
        .i_clk       (i_clk),
        .i_en        (w_en),
        .i_y         ({{12{r_y0[19]}}, r_y0}),
        .i_x         ({{12{r_x0[19]}}, r_x0}),
        .i_force_zero(1'b0),
        .o_ang       (w_yaw)
    );

    lik_sqrt u_sqrt_r (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_v   ({22'd0, r_rsq}),
        .o_root(w_r)
    );

    lik_cordic u_beta (
        .i_clk       (i_clk),
        .i_en        (w_en),
        .i_y         ({{12{r_z34[19]}}, r_z34}),
        .i_x         ({{11{r_d[20]}}, r_d}),
        .i_force_zero(1'b0),
        .o_ang       (w_beta)
    );

    lik_sqrt u_sqrt_a (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_v   ({22'd0, r_a2}),
        .o_root(w_a)
    );

    always_comb begin
        w_num[0] = $signed(42'(r_l2sq) + 42'(r_l3sq) - 42'(r_a2d[lik_pkg::DLY_A2-1]));
        w_num[1] = $signed(42'(r_a2d[lik_pkg::DLY_A2-1]) + 42'(r_l2sq) - 42'(r_l3sq));
        w_den[0] = r_den1;
        w_den[1] = 41'({w_al2, 1'b0});
    end

    for (genvar g = 0; g < 2; g++) begin : g_acos
        logic signed [41:0]  r_num;
        logic [40:0]         r_den;
        logic [41:0]         w_mag;
        logic                w_den0;
        lik_pkg::t_acos_ctl  n_ctl;
        logic [40:0]         r_m;
        logic [40:0]         r_dv;
        lik_pkg::t_acos_ctl  r_ctl [lik_pkg::DLY_CTL+1];
        logic [29:0]         w_q;
        logic [30:0]         r_q;
        logic [32:0]         r_czd [lik_pkg::DLY_CZ+1];
        logic                r_fl;
        logic [61:0]         w_qq;
        logic [60:0]         r_qq;
        logic [60:0]         r_sv;
        logic [30:0]         w_s;

        always_comb begin
            w_mag      = r_num[41] ? 42'(-r_num) : 42'(r_num);
            w_den0     = r_den == '0;
            n_ctl.zero = w_den0;
            n_ctl.sat  = w_den0 || (w_mag[40:0] >= r_den);
            n_ctl.flag = w_den0 || (w_mag[40:0] > r_den);
            n_ctl.neg  = !w_den0 && r_num[41];
        end

        assign w_qq = r_q * r_q;

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_num    <= w_num[g];
                r_den    <= w_den[g];
                r_m      <= w_mag[40:0];
                r_dv     <= r_den;
                r_ctl[0] <= n_ctl;
                for (int k = 1; k <= lik_pkg::DLY_CTL; k++) begin
                    r_ctl[k] <= r_ctl[k-1];
                end
                r_q  <= r_ctl[lik_pkg::DLY_CTL].sat ? 31'h4000_0000 : {1'b0, w_q};
                r_fl <= r_ctl[lik_pkg::DLY_CTL].flag;
                r_czd[0] <= {r_ctl[lik_pkg::DLY_CTL].zero,
                             r_ctl[lik_pkg::DLY_CTL].neg
                                 ? 32'(-(r_ctl[lik_pkg::DLY_CTL].sat ? 32'h4000_0000
                                                                     : {2'b00, w_q}))
                                 : (r_ctl[lik_pkg::DLY_CTL].sat ? 32'h4000_0000
                                                                : {2'b00, w_q})};
                for (int k = 1; k <= lik_pkg::DLY_CZ; k++) begin
                    r_czd[k] <= r_czd[k-1];
                end
                r_qq <= w_qq[60:0];
                r_sv <= 61'h1000_0000_0000_0000 - r_qq;
            end
        end

        lik_div u_div (
            .i_clk(i_clk),
            .i_en (w_en),
            .i_m  (r_m),
            .i_den(r_dv),
            .o_q  (w_q)
        );

        lik_sqrt u_sqrt_s (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_v   ({1'b0, r_sv}),
            .o_root(w_s)
        );

        lik_cordic u_acos (
            .i_clk       (i_clk),
            .i_en        (w_en),
            .i_y         ({1'b0, w_s}),
            .i_x         (r_czd[lik_pkg::DLY_CZ][31:0]),
            .i_force_zero(r_czd[lik_pkg::DLY_CZ][32]),
            .o_ang       (w_ang[g])
        );

        assign w_fl[g] = r_fl;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_yawd[0]  <= w_yaw;
            r_betad[0] <= w_beta;
            r_fld[0]   <= w_fl[0] || w_fl[1];
            for (int k = 1; k < lik_pkg::DLY_YAW; k++) begin
                r_yawd[k] <= r_yawd[k-1];
            end
            for (int k = 1; k < lik_pkg::DLY_BETA; k++) begin
                r_betad[k] <= r_betad[k-1];
            end
            for (int k = 1; k < lik_pkg::DLY_FLAG; k++) begin
                r_fld[k] <= r_fld[k-1];
            end
        end
    end

    always_comb begin
        w_knee   = 32'h4000_0000 - w_ang[0];
        w_hip    = 32'd0 - (w_ang[1] + r_betad[lik_pkg::DLY_BETA-1]);
        w_yaw_r  = r_yawd[lik_pkg::DLY_YAW-1] + 32'h0000_8000;
        w_hip_r  = w_hip + 32'h0000_8000;
        w_knee_r = w_knee + 32'h0000_8000;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.yaw_angle    <= w_yaw_r[31:16];
            r_out.hip_angle    <= w_hip_r[31:16];
            r_out.knee_angle   <= w_knee_r[31:16];
            r_out.out_of_reach <= r_fld[lik_pkg::DLY_FLAG-1];
        end
    end

    `LIK_ASSERT_NXT(a_advance, i_clk, i_rst_n, w_en && r_vld[ST_F], o_out_valid)
    `LIK_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)
    `LIK_ASSERT_IMP(a_den0_flag, i_clk, i_rst_n, o_out_valid && r_den1 == '0, o_out_data.out_of_reach)

endmodule

[sim/leg_inverse_kinematics_3dof_core_tb.sv]
module leg_inverse_kinematics_3dof_core_tb;

    localparam int STAGES     = lik_pkg::CORDIC_STAGES;
    localparam int LATENCY    = lik_pkg::ST_F + 1;
    localparam int IDLE_LIMIT = 20000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    lik_pkg::t_in      i_in_data;
    logic              o_in_stall;
    logic              o_out_valid;
    lik_pkg::t_out     o_out_data;
    logic              i_out_stall;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    lik_pkg::t_reg_idx i_cfg_index;
    logic [18:0]       i_cfg_data;

    leg_inverse_kinematics_3dof_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    longint unsigned link1_len, link2_len, link3_len;
    lik_pkg::t_out   angle_q[$];
    int              n_errors;
    int              idle_cycles;
    bit              no_idle;
    bit              hold_off;
    int              hold_cycles;

    localparam longint unsigned ATAN_TAB[24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] cordic_atan2(longint y, longint x);
        logic [31:0] ang;
        longint      t, dx, dy;
        ang = 0;
        if (x == 0 && y == 0) return 0;
        while ((x < 0 ? -x : x) < (64'sd1 <<< 40) && (y < 0 ? -y : y) < (64'sd1 <<< 40)) begin
            x = x * 2;
            y = y * 2;
        end
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                ang = 32'h4000_0000;
            end else begin
                x = -y;
                y = t;
                ang = 32'hC000_0000;
            end
        end
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx;
                y = y - dy;
                ang = ang + 32'(ATAN_TAB[i]);
            end else begin
                x = x - dx;
                y = y + dy;
                ang = ang - 32'(ATAN_TAB[i]);
            end
        end
        return ang;
    endfunction

    function automatic logic [31:0] acos_angle(longint num, longint unsigned den,
                                               inout bit flag);
        longint unsigned m, rem, q;
        longint          c;
        m = num < 0 ? -num : num;
        q = 0;
        if (den == 0) begin
            flag = 1;
            return 0;
        end
        if (m >= den) begin
            if (m > den) flag = 1;
            q = 64'd1 << 30;
        end else begin
            rem = m;
            for (int i = 0; i < 30; i++) begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= den) begin
                    rem = rem - den;
                    q = q | 1;
                end
            end
        end
        c = num < 0 ? -longint'(q) : longint'(q);
        return cordic_atan2(longint'(int_sqrt((64'd1 << 60) - q * q)), c);
    endfunction

    function automatic lik_pkg::t_out solve_leg(lik_pkg::t_in t);
        longint          x, y, z, l2, l3, d, a2;
        longint unsigned r, a;
        logic [31:0]     yaw, kc, gam, bet, hip, knee;
        bit              flag;
        lik_pkg::t_out   o;
        x = t.target_x;
        y = t.target_y;
        z = t.target_z;
        l2 = link2_len;
        l3 = link3_len;
        flag = 0;
        yaw = cordic_atan2(y, x);
        r = int_sqrt(x * x + y * y);
        d = longint'(r) - longint'(link1_len);
        a2 = d * d + z * z;
        a = int_sqrt(a2);
        kc = acos_angle(l2 * l2 + l3 * l3 - a2, 2 * l2 * l3, flag);
        gam = acos_angle(a2 + l2 * l2 - l3 * l3, 2 * a * l2, flag);
        bet = cordic_atan2(z, d);
        knee = 32'h4000_0000 - kc;
        hip = 32'd0 - (gam + bet);
        o.yaw_angle = 16'((yaw + 32'h8000) >> 16);
        o.hip_angle = 16'((hip + 32'h8000) >> 16);
        o.knee_angle = 16'((knee + 32'h8000) >> 16);
        o.out_of_reach = flag;
        return o;
    endfunction

    task automatic send_target(logic signed [19:0] x, logic signed [19:0] y,
                               logic signed [19:0] z);
        lik_pkg::t_in t;
        t.target_x = x;
        t.target_y = y;
        t.target_z = z;
        while (!no_idle && $urandom_range(99) < 20) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= t;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        angle_q.push_back(solve_leg(t));
    endtask

    task automatic write_link(lik_pkg::t_reg_idx idx, logic [18:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            lik_pkg::REG_LINK1: link1_len = val;
            lik_pkg::REG_LINK2: link2_len = val;
            default:            link3_len = val;
        endcase
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (angle_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic set_links(logic [18:0] l1, logic [18:0] l2, logic [18:0] l3);
        drain();
        write_link(lik_pkg::REG_LINK1, l1);
        write_link(lik_pkg::REG_LINK2, l2);
        write_link(lik_pkg::REG_LINK3, l3);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_links;
        send_target(20'sd1000, 20'sd0, -20'sd2000);
        send_target(20'sd0, 20'sd0, 20'sd0);
    endtask

    task automatic test_directed;
        set_links(19'd3000, 19'd6000, 19'd6000);
        send_target(20'sd0, 20'sd0, 20'sd0);
        send_target(20'sd3000, 20'sd0, -20'sd12000);
        send_target(20'sd3000, 20'sd0, -20'sd20000);
        send_target(20'sd15000, 20'sd0, 20'sd0);
        send_target(20'sd3000, 20'sd0, 20'sd0);
        send_target(-20'sd5000, 20'sd4000, -20'sd6000);
        send_target(-20'sd5000, -20'sd4000, 20'sd6000);
        send_target(20'sd0, -20'sd9000, -20'sd5000);
        send_target(-20'sd524288, -20'sd524288, -20'sd524288);
        send_target(20'sd524287, 20'sd524287, 20'sd524287);
        send_target(-20'sd524288, 20'sd524287, 20'sd0);
        send_target(-20'sd1, 20'sd0, 20'sd1);
        set_links(19'd524287, 19'd524287, 19'd524287);
        send_target(20'sd524287, 20'sd524287, 20'sd524287);
        send_target(-20'sd524288, 20'sd0, -20'sd524288);
        send_target(20'sd0, 20'sd0, 20'sd0);
        set_links(19'd0, 19'd5000, 19'd0);
        send_target(20'sd4000, 20'sd100, -20'sd3000);
    endtask

    task automatic test_random(int n, bit reachable);
        int s;
        s = int'(link2_len + link3_len + 1);
        for (int i = 0; i < n; i++) begin
            if (reachable && $urandom_range(9) != 0)
                send_target(20'($signed($urandom_range(2 * s)) - s),
                            20'($signed($urandom_range(2 * s)) - s),
                            20'($signed($urandom_range(2 * s)) - s));
            else
                send_target(20'($urandom), 20'($urandom), 20'($urandom));
        end
    endtask

    task automatic test_back_pressure;
        hold_cycles = 400;
        hold_off = 1'b1;
        no_idle = 1'b1;
        test_random(250, 1);
        no_idle = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_off) begin
            i_out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
            if (hold_cycles <= 1) hold_off <= 1'b0;
        end else begin
            i_out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 20);
        end
    end

    always @(posedge i_clk) begin
        lik_pkg::t_out e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (angle_q.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_out_data);
                n_errors++;
            end else begin
                e = angle_q.pop_front();
                if (o_out_data.yaw_angle !== e.yaw_angle) begin
                    $display("%0t: yaw exp %0d got %0d", $time, e.yaw_angle,
                             o_out_data.yaw_angle);
                    n_errors++;
                end
                if (o_out_data.hip_angle !== e.hip_angle) begin
                    $display("%0t: hip exp %0d got %0d", $time, e.hip_angle,
                             o_out_data.hip_angle);
                    n_errors++;
                end
                if (o_out_data.knee_angle !== e.knee_angle) begin
                    $display("%0t: knee exp %0d got %0d", $time, e.knee_angle,
                             o_out_data.knee_angle);
                    n_errors++;
                end
                if (o_out_data.out_of_reach !== e.out_of_reach) begin
                    $display("%0t: out_of_reach exp %0d got %0d", $time,
                             e.out_of_reach, o_out_data.out_of_reach);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        n_errors = 0;
        idle_cycles = 0;
        no_idle = 1'b0;
        hold_off = 1'b0;
        hold_cycles = 0;
        link1_len = 0;
        link2_len = 0;
        link3_len = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = lik_pkg::REG_LINK1;
        i_cfg_data = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_links();
        test_directed();
        set_links(19'd3000, 19'd8000, 19'd9000);
        test_random(600, 1);
        test_back_pressure();
        set_links(19'($urandom_range(8000)), 19'($urandom_range(1, 20000)),
                  19'($urandom_range(1, 20000)));
        test_random(450, 1);
        set_links(19'($urandom), 19'($urandom), 19'($urandom));
        test_random(250, 1);
        set_links(19'd0, 19'd0, 19'd0);
        test_random(100, 0);
        set_links(19'd1, 19'd524287, 19'd1);
        test_random(150, 0);
        drain();
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
